// ===== hw/rtl/fcr_pkg.sv =====
// shared constants, types and helper functions of the four-line comb reverb
package fcr_pkg;

    // delay line storage
    localparam int LINE_DEPTH = 2400;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int NUM_LINES  = 4;

    // sample and arithmetic widths
    localparam int SAMPLE_W   = 16;
    localparam int CODE_W     = 8;
    localparam int GAIN_SHIFT = 7;
    localparam int GAIN_W     = 15;
    localparam int FRAC_W     = 15;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SCALED_W   = PROD_W - FRAC_W;
    localparam int WSUM_W     = SCALED_W + 1;
    localparam int TOT_W      = SCALED_W + 3;

    // line lengths: base length and the shortening of each line
    localparam int BASE_LEN  = 500;
    localparam int LEN_STEP  = 7;
    localparam int LINE_OFFSET [NUM_LINES] = '{0, 125, 250, 400};

    // output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LENGTH_CODE = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_GAIN_CODE   = t_cfg_idx'(1);

    // last valid position of line k for a given length code
    function automatic logic [ADDR_W-1:0] line_last(input logic [CODE_W-1:0] code,
                                                    input int k);
        int len;
        len = BASE_LEN + LEN_STEP * int'(code) - LINE_OFFSET[k];
        return ADDR_W'(len - 1);
    endfunction

    // q15 feedback gain; an 8-bit code shifted by 7 never passes 32767
    function automatic logic [GAIN_W-1:0] gain_q15(input logic [CODE_W-1:0] code);
        return GAIN_W'(int'(code) << GAIN_SHIFT);
    endfunction

endpackage

// ===== hw/rtl/four_comb_reverb_unit.sv =====
// Four parallel feedback comb filters forming a reverb, one sample per clock while o_in_stall
// is low. Each accepted word passes through stage a and stage b before its result enters the
// output queue. The rate is set by the four delay-line memories, each read once and written
// once per cycle through a three-stage read, multiply, write-back pipeline. The four-word
// output queue lets input continue while a result waits; input stalls only once four words
// are in flight or queued. Each line keeps a fill count instead of clearing its memory, so
// the block is ready straight after reset. The user must write length and gain through the
// configuration port only while no sample is in flight; the block does not enforce this.
module four_comb_reverb_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [fcr_pkg::SAMPLE_W-1:0] i_sample_in,
    // sample output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [fcr_pkg::SAMPLE_W-1:0] o_sample_out,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  fcr_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [fcr_pkg::CODE_W-1:0]        i_cfg_data
);

    localparam int NL = fcr_pkg::NUM_LINES;
    localparam int AW = fcr_pkg::ADDR_W;
    localparam int SW = fcr_pkg::SAMPLE_W;

    // handshakes
    logic w_in_acc;
    logic w_out_pop;

    // configuration registers
    logic [fcr_pkg::CODE_W-1:0] r_length_code;
    logic [fcr_pkg::CODE_W-1:0] r_gain_code;
    logic [fcr_pkg::GAIN_W-1:0] w_gain;

    // positions and fill counts
    logic [AW-1:0] r_pos  [NL];
    logic [AW-1:0] r_fill [NL];
    logic [AW-1:0] w_last [NL];

    // stage a: read issued
    logic                 r_a_valid;
    logic signed [SW-1:0] r_a_x;
    logic [AW-1:0]        r_a_addr [NL];
    logic [NL-1:0]        r_a_ok;

    // stage b: product registered
    logic                                  r_b_valid;
    logic signed [SW-1:0]                  r_b_x;
    logic [AW-1:0]                         r_b_addr [NL];
    logic signed [fcr_pkg::PROD_W-1:0]     r_b_prod [NL];

    // combinational data paths
    logic signed [SW-1:0]                  w_rd     [NL];
    logic signed [SW-1:0]                  w_d      [NL];
    logic signed [fcr_pkg::PROD_W-1:0]     w_prod   [NL];
    logic signed [fcr_pkg::SCALED_W-1:0]   w_s      [NL];
    logic signed [fcr_pkg::WSUM_W-1:0]     w_wsum   [NL];
    logic signed [SW-1:0]                  w_wr     [NL];
    logic signed [fcr_pkg::TOT_W-1:0]      w_tot;
    logic signed [fcr_pkg::TOT_W-2:0]      w_half;
    logic signed [SW-1:0]                  w_result;

    // output queue and credit count
    logic signed [SW-1:0]          r_fifo [fcr_pkg::OUT_DEPTH];
    logic [fcr_pkg::OUT_PTR_W-1:0] r_wr_ptr;
    logic [fcr_pkg::OUT_PTR_W-1:0] r_rd_ptr;
    logic [fcr_pkg::CNT_W-1:0]     r_fifo_cnt;
    logic [fcr_pkg::CNT_W-1:0]     r_cnt;
    logic [fcr_pkg::CNT_W-1:0]     n_cnt;
    logic [fcr_pkg::CNT_W-1:0]     n_fifo_cnt;

    // handshake decode
    assign o_in_stall  = (r_cnt == fcr_pkg::CNT_W'(fcr_pkg::OUT_DEPTH));
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_fifo_cnt != '0);
    assign w_out_pop   = o_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_code <= '0;
            r_gain_code   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fcr_pkg::CFG_LENGTH_CODE: r_length_code <= i_cfg_data;
                fcr_pkg::CFG_GAIN_CODE:   r_gain_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_gain = fcr_pkg::gain_q15(r_gain_code);

    // wrap point of each line
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_last[k] = fcr_pkg::line_last(r_length_code, k);
        end
    end

    // position advance and fill tracking; written entries always form a prefix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NL; k++) begin
                r_pos[k]  <= '0;
                r_fill[k] <= '0;
            end
        end else if (w_in_acc) begin
            for (int k = 0; k < NL; k++) begin
                r_pos[k] <= (r_pos[k] < w_last[k]) ? r_pos[k] + AW'(1) : '0;
                if (r_pos[k] == r_fill[k]) begin
                    r_fill[k] <= r_fill[k] + AW'(1);
                end
            end
        end
    end

    // delay line memories: read at the current position, write back from stage b
    for (genvar k = 0; k < NL; k++) begin : g_line
        logic [SW-1:0] r_mem [fcr_pkg::LINE_DEPTH];
        logic [SW-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (r_b_valid) begin
                r_mem[r_b_addr[k]] <= w_wr[k];
            end
            if (w_in_acc) begin
                r_rd <= r_mem[r_pos[k]];
            end
        end

        assign w_rd[k] = $signed(r_rd);
    end

    // stage a control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_x <= i_sample_in;
            for (int k = 0; k < NL; k++) begin
                r_a_addr[k] <= r_pos[k];
                r_a_ok[k]   <= (r_pos[k] < r_fill[k]);
            end
        end
    end

    // gain multiply; unwritten entries read as zero
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_d[k]    = r_a_ok[k] ? w_rd[k] : '0;
            w_prod[k] = w_d[k] * $signed({1'b0, w_gain});
        end
    end

    // stage b control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_x <= r_a_x;
            for (int k = 0; k < NL; k++) begin
                r_b_addr[k] <= r_a_addr[k];
                r_b_prod[k] <= w_prod[k];
            end
        end
    end

    // scale, feedback word and output sum
    always_comb begin
        w_tot = fcr_pkg::TOT_W'(r_b_x);
        for (int k = 0; k < NL; k++) begin
            w_s[k]    = r_b_prod[k][fcr_pkg::PROD_W-1:fcr_pkg::FRAC_W];
            w_wsum[k] = fcr_pkg::WSUM_W'(r_b_x) + fcr_pkg::WSUM_W'(w_s[k]);
            w_wr[k]   = w_wsum[k][SW:1];
            w_tot     = w_tot + fcr_pkg::TOT_W'(w_s[k]);
        end
        w_half = w_tot[fcr_pkg::TOT_W-1:1];
        if (w_half > (fcr_pkg::TOT_W-1)'(32767)) begin
            w_result = 16'sh7FFF;
        end else if (w_half < -(fcr_pkg::TOT_W-1)'(32768)) begin
            w_result = 16'sh8000;
        end else begin
            w_result = w_half[SW-1:0];
        end
    end

    // output queue
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_fifo[r_wr_ptr] <= w_result;
        end
    end

    always_comb begin
        n_fifo_cnt = r_fifo_cnt;
        if (r_b_valid) begin
            n_fifo_cnt = n_fifo_cnt + fcr_pkg::CNT_W'(1);
        end
        if (w_out_pop) begin
            n_fifo_cnt = n_fifo_cnt - fcr_pkg::CNT_W'(1);
        end
        n_cnt = r_cnt;
        if (w_in_acc) begin
            n_cnt = n_cnt + fcr_pkg::CNT_W'(1);
        end
        if (w_out_pop) begin
            n_cnt = n_cnt - fcr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_cnt      <= '0;
        end else begin
            if (r_b_valid) begin
                r_wr_ptr <= r_wr_ptr + fcr_pkg::OUT_PTR_W'(1);
            end
            if (w_out_pop) begin
                r_rd_ptr <= r_rd_ptr + fcr_pkg::OUT_PTR_W'(1);
            end
            r_fifo_cnt <= n_fifo_cnt;
            r_cnt      <= n_cnt;
        end
    end

    assign o_sample_out = r_fifo[r_rd_ptr];

    // credit count covers every word in the pipe and the queue
    a_queue_le_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_cnt)
        else $error("output queue holds more words than are in flight");

    // a finishing word always finds room in the queue
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_fifo_cnt < fcr_pkg::CNT_W'(fcr_pkg::OUT_DEPTH)))
        else $error("output queue overflow");

    for (genvar k = 0; k < NL; k++) begin : g_chk
        // a read never hits the entry being written back
        a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (w_in_acc && r_b_valid) |-> (r_pos[k] != r_b_addr[k]))
            else $error("delay line read collides with pending write");

        // position never runs past the written prefix
        a_pos_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_pos[k] <= r_fill[k])
            else $error("position beyond fill count");
    end

endmodule
